### rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Word width, action codes and the divider command/response records.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WordBits = 32;
  localparam int CntBits  = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_SUB    = 3'd1,
    ACT_MUL    = 3'd2,
    ACT_DIV    = 3'd3,
    ACT_REDUCE = 3'd4
  } action_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_cmd_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage : rau_pkg
`default_nettype wire

### rtl/rau_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_divider: unsigned restoring divider
// One quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module rau_divider
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_cmd_t cmd,
  output div_rsp_t      rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  word_t               quot_r, quot_nxt;
  word_t               rem_r, rem_nxt;
  word_t               dvs_r, dvs_nxt;
  logic [WordBits:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quot_r[WordBits-1]} - {1'b0, dvs_r};
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntBits'(WordBits);
      quot_nxt = cmd.dividend;
      rem_nxt  = '0;
      dvs_nxt  = cmd.divisor;
    end else if (busy_r) begin
      // shift next dividend bit in, keep remainder if it fits
      if (!trial[WordBits]) begin
        rem_nxt = trial[WordBits-1:0];
        quot_nxt = {quot_r[WordBits-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WordBits-2:0], quot_r[WordBits-1]};
        quot_nxt = {quot_r[WordBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule : rau_divider
`default_nettype wire

### rtl/rational_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arith_unit: signed fraction add, subtract, multiply, divide, reduce
// Sequenced datapath with one multiplier and one shared serial divider.
// ----------------------------------------------------------------------------
// One transaction at a time. Add and subtract with equal denominators have the
// result registered in the cycle after acceptance; otherwise the states S_MUL1,
// S_MUL2 and S_ADDS form three products on the shared multiplier, the last one
// together with the sum. Multiply, divide and reduce run Euclid's gcd on the
// shared restoring divider, one remainder per division, then two more divisions
// by the gcd; consecutive Fibonacci operands give the longest gcd chain.
// in_stall is high from acceptance until the result has been taken.
module rational_arith_unit
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_a_num,
  input  wire logic [31:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [31:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_res_num,
  output logic [31:0]      out_res_den,
  output logic             out_bad_operand
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_ADDS, S_RED, S_GCD, S_GCDW,
    S_QN, S_QNW, S_QD, S_QDW, S_OUT
  } state_t;

  state_t   state_r;
  action_t  act_r;
  word_t    an_r, ad_r, bn_r, bd_r;
  word_t    p0_r, p1_r;
  word_t    n_r, d_r, x_r, y_r, mag_r;
  logic     neg_r;
  word_t    rn_r, rd_r;
  logic     bad_r;
  logic     ovalid_r;
  div_cmd_t dcmd;
  div_rsp_t drsp;

  word_t mul_a, mul_b, mul_p;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    if (state_r == S_MUL2) begin
      unique case (act_r)
        ACT_ADD, ACT_SUB: begin mul_a = bn_r; mul_b = ad_r; end
        default:          begin mul_a = ad_r; mul_b = bd_r; end
      endcase
    end else if (state_r == S_ADDS) begin
      mul_a = ad_r;
      mul_b = bd_r;
    end else begin
      unique case (act_r)
        ACT_ADD, ACT_SUB: begin mul_a = an_r; mul_b = bd_r; end
        default:          begin mul_a = an_r; mul_b = bn_r; end
      endcase
    end
  end

  always_comb begin
    dcmd.start    = 1'b0;
    dcmd.dividend = x_r;
    dcmd.divisor  = y_r;
    unique case (state_r)
      S_GCD: dcmd.start = (y_r != '0);
      S_QN: begin dcmd.start = 1'b1; dcmd.dividend = mag_r; dcmd.divisor = x_r; end
      S_QD: begin dcmd.start = 1'b1; dcmd.dividend = d_r;   dcmd.divisor = x_r; end
      default: ;
    endcase
  end

  rau_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (dcmd),
    .rsp   (drsp)
  );

  word_t sum_w;
  assign sum_w = p0_r + p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          act_r <= action_t'(in_action);
          an_r  <= in_a_num;
          ad_r  <= in_a_den;
          bn_r  <= (in_action == 3'(ACT_SUB)) ? -in_b_num :
                   (in_action == 3'(ACT_DIV)) ? in_b_den : in_b_num;
          bd_r  <= (in_action == 3'(ACT_DIV)) ? in_b_num : in_b_den;
          rn_r  <= '0;
          rd_r  <= 32'd1;
          bad_r <= 1'b0;
          if (in_action > 3'(ACT_REDUCE) || in_a_den == '0 ||
              (in_action != 3'(ACT_REDUCE) && in_b_den == '0) ||
              (in_action == 3'(ACT_DIV) && in_b_num == '0)) begin
            bad_r    <= 1'b1;
            ovalid_r <= 1'b1;
            state_r  <= S_OUT;
          end else if (in_action == 3'(ACT_REDUCE)) begin
            n_r     <= in_a_num;
            d_r     <= in_a_den;
            state_r <= S_RED;
          end else if (in_action <= 3'(ACT_SUB) && in_a_den == in_b_den) begin
            rn_r     <= in_a_num + ((in_action == 3'(ACT_SUB)) ? -in_b_num : in_b_num);
            rd_r     <= in_a_den;
            ovalid_r <= 1'b1;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          p0_r    <= mul_p;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p1_r <= mul_p;
          if (act_r == ACT_ADD || act_r == ACT_SUB) begin
            state_r <= S_ADDS;
          end else begin
            n_r <= p0_r;
            d_r <= mul_p;
            if (p0_r == '0) begin
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else if (mul_p == '0) begin
              bad_r    <= 1'b1;
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_RED;
            end
          end
        end
        S_ADDS: begin
          // cross-multiplied sum; shared multiplier now gives ad*bd
          if (sum_w == '0) begin
            rn_r <= '0;
            rd_r <= 32'd1;
          end else if (mul_p == '0) begin
            bad_r <= 1'b1;
          end else begin
            rn_r <= sum_w;
            rd_r <= mul_p;
          end
          ovalid_r <= 1'b1;
          state_r  <= S_OUT;
        end
        S_RED: begin
          // sign to numerator, then start gcd on magnitudes
          if (n_r == '0) begin
            ovalid_r <= 1'b1;
            state_r  <= S_OUT;
          end else begin
            logic [31:0] nn, dd, mm;
            nn = d_r[31] ? -n_r : n_r;
            dd = d_r[31] ? -d_r : d_r;
            mm = nn[31] ? -nn : nn;
            neg_r   <= nn[31];
            d_r     <= dd;
            mag_r   <= mm;
            x_r     <= mm;
            y_r     <= dd;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (y_r == '0) state_r <= S_QN;
          else           state_r <= S_GCDW;
        end
        S_GCDW: if (drsp.done) begin
          x_r     <= y_r;
          y_r     <= drsp.rem;
          state_r <= S_GCD;
        end
        S_QN: state_r <= S_QNW;
        S_QNW: if (drsp.done) begin
          rn_r    <= neg_r ? -drsp.quot : drsp.quot;
          state_r <= S_QD;
        end
        S_QD: state_r <= S_QDW;
        S_QDW: if (drsp.done) begin
          rd_r     <= drsp.quot;
          ovalid_r <= 1'b1;
          state_r  <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          ovalid_r <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_res_num     = bad_r ? '0 : rn_r;
  assign out_res_den     = bad_r ? 32'd1 : rd_r;
  assign out_bad_operand = bad_r;

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result valid outside output state");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_operand |-> out_res_num == '0 && out_res_den == 32'd1)
    else $error("error result not 0/1");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_GCDW || state_r == S_QNW || state_r == S_QDW)
    else $error("divider done while not waiting");

endmodule : rational_arith_unit
`default_nettype wire

### test/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_tb: self-checking bench for the rational arithmetic unit
// Runs a directed table of corner cases, then random transactions, with
// random gaps and stalls on both channels. Every result is checked against
// the expected value given in its table row or else a predictor of the fraction math.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
  import rau_pkg::*;

  localparam int          NumRandom    = 430;
  localparam int          CycleLimit   = 3000000;
  localparam int          DrainCycles  = 50;
  localparam logic [2:0]  ActUnusedLo  = 3'd5;
  localparam logic [2:0]  ActUnusedHi  = 3'd7;
  localparam word_t       MinWord      = 32'h8000_0000;
  localparam word_t       MaxWord      = 32'h7fff_ffff;

  typedef struct packed {
    word_t num;
    word_t den;
    logic  bad;
  } frac_t;

  typedef struct packed {
    logic [2:0] act;
    word_t      a_num;
    word_t      a_den;
    word_t      b_num;
    word_t      b_den;
    logic       typed;
    frac_t      res;
  } vec_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_action = '0;
  word_t      in_a_num = '0;
  word_t      in_a_den = '0;
  word_t      in_b_num = '0;
  word_t      in_b_den = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  word_t      out_res_num;
  word_t      out_res_den;
  logic       out_bad_operand;

  frac_t pending_fracs[$];
  int    err_count = 0;
  int    sent_count = 0;
  int    recv_count = 0;
  int    bad_count = 0;
  int    cycle_count = 0;

  rational_arith_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_a_num       (in_a_num),
    .in_a_den       (in_a_den),
    .in_b_num       (in_b_num),
    .in_b_den       (in_b_den),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res_num    (out_res_num),
    .out_res_den    (out_res_den),
    .out_bad_operand(out_bad_operand)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t gcd_word(word_t x, word_t y);
    word_t r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // sign goes to the numerator, denominator then read as unsigned
  function automatic frac_t reduce_frac(word_t n, word_t d);
    frac_t f;
    word_t mag, g;
    logic  neg;
    f.bad = 1'b0;
    if (d[31]) begin
      n = -n;
      d = -d;
    end
    if (n == 0) begin
      f.num = '0;
      f.den = 32'd1;
      return f;
    end
    neg = n[31];
    mag = neg ? -n : n;
    g = gcd_word(mag, d);
    f.num = neg ? -(mag / g) : mag / g;
    f.den = d / g;
    return f;
  endfunction

  function automatic frac_t predict_fraction(logic [2:0] act, word_t an, word_t ad,
                                             word_t bn, word_t bd);
    frac_t f;
    word_t mn, md, t;
    f = '{num: '0, den: 32'd1, bad: 1'b0};
    if (act > ACT_REDUCE || ad == 0 || (act != ACT_REDUCE && bd == 0) ||
        (act == ACT_DIV && bn == 0)) begin
      f.bad = 1'b1;
    end else if (act == ACT_ADD || act == ACT_SUB) begin
      if (act == ACT_SUB) bn = -bn;
      if (ad == bd) begin
        f.num = an + bn;
        f.den = ad;
      end else begin
        f.num = an * bd + bn * ad;
        f.den = (f.num == 0) ? 32'd1 : ad * bd;
        if (f.den == 0) f.bad = 1'b1;
      end
    end else if (act == ACT_MUL || act == ACT_DIV) begin
      if (act == ACT_DIV) begin
        t = bn;
        bn = bd;
        bd = t;
      end
      mn = an * bn;
      md = (mn == 0) ? 32'd1 : ad * bd;
      if (md == 0) f.bad = 1'b1;
      else f = reduce_frac(mn, md);
    end else begin
      f = reduce_frac(an, ad);
    end
    if (f.bad) begin
      f.num = '0;
      f.den = 32'd1;
    end
    return f;
  endfunction

  function automatic vec_t row(logic [2:0] act, word_t an, word_t ad, word_t bn, word_t bd);
    return '{act: act, a_num: an, a_den: ad, b_num: bn, b_den: bd, typed: 1'b0, res: '0};
  endfunction

  function automatic vec_t row_exp(logic [2:0] act, word_t an, word_t ad, word_t bn,
                                   word_t bd, word_t rn, word_t rd, logic bad);
    vec_t v;
    v = row(act, an, ad, bn, bd);
    v.typed = 1'b1;
    v.res = '{num: rn, den: rd, bad: bad};
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_fraction(vec_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= v.act;
    in_a_num  <= v.a_num;
    in_a_den  <= v.a_den;
    in_b_num  <= v.b_num;
    in_b_den  <= v.b_den;
    do @(posedge clk); while (in_stall);
    pending_fracs.push_back(v.typed ? v.res
        : predict_fraction(v.act, v.a_num, v.a_den, v.b_num, v.b_den));
    sent_count++;
  endtask

  function automatic word_t rand_operand(int mode);
    case (mode)
      0: return word_t'($urandom_range(0, 2000)) - 32'd1000;
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: return MinWord;
          1: return MaxWord;
          2: return '0;
          3: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    int   mode, r;
    r = $urandom_range(0, 99);
    mode = (r < 65) ? 0 : (r < 90) ? 1 : 2;
    v = row(3'($urandom_range(ACT_ADD, ACT_REDUCE)), rand_operand(mode),
            rand_operand(mode), rand_operand(mode), rand_operand(mode));
    // keep most denominators nonzero so the arithmetic paths get exercised
    if (v.a_den == 0 && $urandom_range(0, 3) != 0) v.a_den = 32'd7;
    if (v.b_den == 0 && $urandom_range(0, 3) != 0) v.b_den = 32'd3;
    if ($urandom_range(0, 99) < 3) v.act = 3'($urandom_range(ActUnusedLo, ActUnusedHi));
    if ($urandom_range(0, 99) < 4) v.b_num = '0;
    return v;
  endfunction

  // receiver stalls, with one long hold-off once traffic is flowing
  initial begin : stall_proc
    int burst;
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 120) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 2) == 0) begin
        burst = pick_gap();
        out_stall <= (burst > 0);
        repeat (burst) @(posedge clk);
        if (burst > 0) out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    frac_t want;
    if (rst_n && out_valid && !out_stall) begin
      recv_count++;
      if (pending_fracs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transaction %h/%h bad=%b", $time, out_res_num,
                 out_res_den, out_bad_operand);
      end else begin
        want = pending_fracs.pop_front();
        if (want.bad) bad_count++;
        if (out_res_num !== want.num) begin
          err_count++;
          $display("%0t: res_num expected %h actual %h", $time, want.num, out_res_num);
        end
        if (out_res_den !== want.den) begin
          err_count++;
          $display("%0t: res_den expected %h actual %h", $time, want.den, out_res_den);
        end
        if (out_bad_operand !== want.bad) begin
          err_count++;
          $display("%0t: bad_operand expected %b actual %b", $time, want.bad,
                   out_bad_operand);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycle_count,
               pending_fracs.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stim_proc
    vec_t table_rows[$];
    table_rows = '{
      row_exp(ACT_REDUCE, 32'd6, 32'd4, 32'd0, 32'd0, 32'd3, 32'd2, 1'b0),
      row_exp(ACT_REDUCE, 32'd0, 32'd5, 32'd9, 32'd0, 32'd0, 32'd1, 1'b0),
      row_exp(ACT_REDUCE, 32'd5, -32'd10, 32'd0, 32'd1, -32'd1, 32'd2, 1'b0),
      row_exp(ACT_REDUCE, MinWord, 32'd1, 32'd0, 32'd1, MinWord, 32'd1, 1'b0),
      row_exp(ACT_ADD, 32'd1, 32'd3, 32'd1, 32'd3, 32'd2, 32'd3, 1'b0),
      row_exp(ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 32'd0, 32'd2, 1'b0),
      row_exp(ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd3, 32'd0, 32'd1, 1'b1),
      row_exp(ACT_MUL, 32'd1, 32'd3, 32'd1, 32'd0, 32'd0, 32'd1, 1'b1),
      row_exp(ACT_DIV, 32'd1, 32'd3, 32'd0, 32'd5, 32'd0, 32'd1, 1'b1),
      row_exp(ActUnusedLo, 32'd1, 32'd3, 32'd1, 32'd3, 32'd0, 32'd1, 1'b1),
      row_exp(ActUnusedHi, MaxWord, MaxWord, MaxWord, MaxWord, 32'd0, 32'd1, 1'b1),
      row_exp(ACT_ADD, 32'd1, 32'h0001_0000, 32'd2, 32'hffff_0000, 32'd0, 32'd1, 1'b1),
      row(ACT_ADD, 32'd1, 32'h0001_0000, 32'd1, 32'hffff_0000),
      row(ACT_SUB, MaxWord, MinWord, MinWord, MaxWord),
      row(ACT_MUL, MinWord, MinWord, MaxWord, MaxWord),
      row(ACT_DIV, 32'hffff_ffff, MaxWord, MinWord, 32'hffff_ffff),
      row(ACT_REDUCE, 32'd3, MinWord, 32'd0, 32'd0),
      row(ACT_REDUCE, MinWord, MinWord, 32'd0, 32'd0),
      row(ACT_REDUCE, 32'd1836311903, 32'd1134903170, 32'd0, 32'd0),
      row(ACT_MUL, 32'd12, -32'd35, 32'd14, 32'd18),
      row(ACT_DIV, -32'd4, 32'd9, 32'd6, -32'd27),
      row(ACT_MUL, 32'd0, 32'd5, 32'd7, 32'd9)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) send_fraction(table_rows[i]);
    repeat (NumRandom) send_fraction(rand_vec());
    in_valid <= 1'b0;
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("%0d transactions sent (%0d directed), %0d results checked, %0d flagged bad",
             sent_count, table_rows.size(), recv_count, bad_count);
    $display("covered all actions, unused codes, zero and wrapping denominators, extremes");
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
